>>> rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W      = 16;
	localparam int DMAG_W      = 33;
	localparam int ROOT_W      = 32;
	localparam int UN_W        = 33;
	localparam int VAL_W       = 32;
	localparam int SQRT_SCALE  = 15;
	localparam int DIV_N_W     = 66;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_TWO_REAL = 2'd0;
	localparam kind_t KIND_DOUBLE   = 2'd1;
	localparam kind_t KIND_COMPLEX  = 2'd2;
	localparam kind_t KIND_DEGEN    = 2'd3;

	typedef struct packed {
		kind_t                     kind;
		logic [DMAG_W-1:0]         d_mag;
		logic signed [COEF_W-1:0]  a;
		logic signed [COEF_W-1:0]  b;
	} item_t;

endpackage

>>> rtl/core/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_coef_if / qrs_root_if
// Valid/ready channels for coefficient requests and root results.
// ----------------------------------------------------------------------------
interface qrs_coef_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] coef_a;
	logic signed [15:0] coef_b;
	logic signed [15:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
	logic               valid;
	logic               ready;
	logic [1:0]         root_kind;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;
	logic               saturated;

	modport source (output valid, root_kind, first_value, second_value, saturated,
		input ready);
	modport sink (input valid, root_kind, first_value, second_value, saturated,
		output ready);
endinterface

>>> rtl/core/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficient requests, forms the discriminant and classifies them.
// ----------------------------------------------------------------------------
module qrs_front
	import qrs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	qrs_coef_if.sink coef_in,
	input  logic    full,
	output logic    push,
	output item_t   item
);

	logic                    v_q;
	logic signed [15:0]      a_q;
	logic signed [15:0]      b_q;
	logic signed [31:0]      bb_q;
	logic signed [31:0]      ac_q;
	logic signed [33:0]      d;
	logic                    take;

	assign take          = !v_q || !full;
	assign coef_in.ready = take;
	assign push          = v_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= coef_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && coef_in.valid) begin
			a_q  <= coef_in.coef_a;
			b_q  <= coef_in.coef_b;
			bb_q <= coef_in.coef_b * coef_in.coef_b;
			ac_q <= coef_in.coef_a * coef_in.coef_c;
		end
	end

	always_comb begin
		d = 34'(bb_q) - (34'(ac_q) <<< 2);
		item.a = a_q;
		item.b = b_q;
		item.d_mag = d[33] ? 33'(-d) : d[32:0];
		if (a_q == '0) begin
			item.kind = KIND_DEGEN;
		end else if (d == '0) begin
			item.kind = KIND_DOUBLE;
		end else if (d[33]) begin
			item.kind = KIND_COMPLEX;
		end else begin
			item.kind = KIND_TWO_REAL;
		end
	end

endmodule

>>> rtl/core/qrs_queue.sv
// ----------------------------------------------------------------------------
// qrs_queue
// Short FIFO between the classifying front and the solving back.
// ----------------------------------------------------------------------------
module qrs_queue
	import qrs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item_i,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t item_o
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     cnt_q;

	assign full   = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty  = cnt_q == '0;
	assign item_o = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_i;
		end
	end

endmodule

>>> rtl/core/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root of d_mag * 2^30, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt
	import qrs_pkg::*;
#(
	parameter int SB_W = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_i,
	input  logic [DMAG_W-1:0] d_mag_i,
	input  logic [SB_W-1:0]   sb_i,
	output logic              v_o,
	output logic [ROOT_W-1:0] root_o,
	output logic [SB_W-1:0]   sb_o
);

	localparam int STEPS = ROOT_W;

	logic              v_s    [STEPS+1];
	logic [63:0]       rad_s  [STEPS+1];
	logic [33:0]       rem_s  [STEPS+1];
	logic [ROOT_W-1:0] root_s [STEPS+1];
	logic [SB_W-1:0]   sb_s   [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= {1'b0, d_mag_i, 30'b0};
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			sb_s[0]   <= sb_i;
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [35:0] rem2;
		logic [35:0] trial;
		logic        ge;

		assign rem2  = {rem_s[k-1], rad_s[k-1][63:62]};
		assign trial = {2'b0, root_s[k-1], 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_s[k-1][61:0], 2'b0};
				rem_s[k]  <= ge ? 34'(rem2 - trial) : rem2[33:0];
				root_s[k] <= {root_s[k-1][ROOT_W-2:0], ge};
				sb_s[k]   <= sb_s[k-1];
			end
		end
	end

	assign v_o    = v_s[STEPS];
	assign root_o = root_s[STEPS];
	assign sb_o   = sb_s[STEPS];

endmodule

>>> rtl/core/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined rounded divide un*2^OFB / (ua*2^16) with sign and saturation.
// ----------------------------------------------------------------------------
module qrs_div
	import qrs_pkg::*;
#(
	parameter int OUT_FRAC_BITS = 16,
	parameter int SB_W          = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_i,
	input  logic [UN_W-1:0]         un_i,
	input  logic [15:0]             ua_i,
	input  logic                    neg_i,
	input  logic [SB_W-1:0]         sb_i,
	output logic                    v_o,
	output logic signed [VAL_W-1:0] val_o,
	output logic                    sat_o,
	output logic [SB_W-1:0]         sb_o
);

	localparam int STEPS = VAL_W;

	logic [DIV_N_W-1:0] n_full;
	logic [32:0]        den;
	logic               ovf;

	logic              v_s    [STEPS+1];
	logic [32:0]       rem_s  [STEPS+1];
	logic [31:0]       low_s  [STEPS+1];
	logic [VAL_W-1:0]  q_s    [STEPS+1];
	logic [32:0]       den_s  [STEPS+1];
	logic              ovf_s  [STEPS+1];
	logic              neg_s  [STEPS+1];
	logic              zero_s [STEPS+1];
	logic [SB_W-1:0]   sb_s   [STEPS+1];

	logic [VAL_W-1:0]  q;
	logic              over;

	assign n_full = (DIV_N_W'(un_i) << (OUT_FRAC_BITS + 1)) + (DIV_N_W'(ua_i) << 16);
	assign den    = {ua_i, 17'b0};
	assign ovf    = n_full[DIV_N_W-1:32] >= 34'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= ovf ? '0 : n_full[64:32];
			low_s[0]  <= n_full[31:0];
			q_s[0]    <= '0;
			den_s[0]  <= den;
			ovf_s[0]  <= ovf;
			neg_s[0]  <= neg_i;
			zero_s[0] <= un_i == '0;
			sb_s[0]   <= sb_i;
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [33:0] r2;
		logic        ge;

		assign r2 = {rem_s[k-1], low_s[k-1][31]};
		assign ge = r2 >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? 33'(r2 - {1'b0, den_s[k-1]}) : r2[32:0];
				low_s[k]  <= {low_s[k-1][30:0], 1'b0};
				q_s[k]    <= {q_s[k-1][VAL_W-2:0], ge};
				den_s[k]  <= den_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				sb_s[k]   <= sb_s[k-1];
			end
		end
	end

	assign q    = q_s[STEPS];
	assign over = ovf_s[STEPS] || (neg_s[STEPS] ? (q[31] && (q[30:0] != '0)) : q[31]);

	always_comb begin
		sat_o = 1'b0;
		if (zero_s[STEPS]) begin
			val_o = '0;
		end else if (over) begin
			sat_o = 1'b1;
			val_o = neg_s[STEPS] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			val_o = neg_s[STEPS] ? -$signed(q) : $signed(q);
		end
	end

	assign v_o  = v_s[STEPS];
	assign sb_o = sb_s[STEPS];

endmodule

>>> rtl/core/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Square root, numerator forming, two dividers and the result register.
// ----------------------------------------------------------------------------
module qrs_back
	import qrs_pkg::*;
#(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       empty,
	output logic       pop,
	qrs_root_if.source root_out
);

	localparam int SB_W = 2 + 2 * COEF_W;

	logic               adv;
	logic               sq_v;
	logic [ROOT_W-1:0]  sq_root;
	logic [SB_W-1:0]    sq_sb;
	kind_t              sq_kind;
	logic signed [15:0] sq_a;
	logic signed [15:0] sq_b;

	logic signed [33:0] bs;
	logic signed [33:0] rt;
	logic signed [33:0] n1;
	logic signed [33:0] n2;

	logic               v_s1;
	kind_t              kind_s1;
	logic [UN_W-1:0]    un1_s1;
	logic [UN_W-1:0]    un2_s1;
	logic               neg1_s1;
	logic               neg2_s1;
	logic [15:0]        ua_s1;

	logic               d1_v;
	logic [VAL_W-1:0]   d1_val;
	logic [VAL_W-1:0]   d2_val;
	logic               d1_sat;
	logic               d2_sat;
	kind_t              d1_kind;

	logic               out_v_q;
	kind_t              kind_q;
	logic [VAL_W-1:0]   first_q;
	logic [VAL_W-1:0]   second_q;
	logic               sat_q;

	assign adv = !out_v_q || root_out.ready;
	assign pop = adv && !empty;

	qrs_sqrt #(.SB_W(SB_W)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.v_i     (!empty),
		.d_mag_i (item.d_mag),
		.sb_i    ({item.kind, item.a, item.b}),
		.v_o     (sq_v),
		.root_o  (sq_root),
		.sb_o    (sq_sb)
	);

	assign {sq_kind, sq_a, sq_b} = sq_sb;

	always_comb begin
		bs = -(34'(sq_b) <<< SQRT_SCALE);
		rt = $signed(34'(sq_root));
		case (sq_kind)
			KIND_TWO_REAL: begin
				n1 = bs + rt;
				n2 = bs - rt;
			end
			KIND_DOUBLE: begin
				n1 = bs;
				n2 = '0;
			end
			KIND_COMPLEX: begin
				n1 = bs;
				n2 = rt;
			end
			default: begin
				n1 = '0;
				n2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= sq_kind;
			un1_s1  <= n1[33] ? 33'(-n1) : n1[32:0];
			un2_s1  <= n2[33] ? 33'(-n2) : n2[32:0];
			neg1_s1 <= n1[33] ^ sq_a[15];
			neg2_s1 <= n2[33] ^ sq_a[15];
			ua_s1   <= sq_a[15] ? 16'(-sq_a) : sq_a;
		end
	end

	qrs_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .SB_W(2)) u_div1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_i    (v_s1),
		.un_i   (un1_s1),
		.ua_i   (ua_s1),
		.neg_i  (neg1_s1),
		.sb_i   (kind_s1),
		.v_o    (d1_v),
		.val_o  (d1_val),
		.sat_o  (d1_sat),
		.sb_o   (d1_kind)
	);

	qrs_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .SB_W(2)) u_div2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_i    (v_s1),
		.un_i   (un2_s1),
		.ua_i   (ua_s1),
		.neg_i  (neg2_s1),
		.sb_i   (kind_s1),
		.v_o    (),
		.val_o  (d2_val),
		.sat_o  (d2_sat),
		.sb_o   ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q   <= d1_kind;
			first_q  <= d1_val;
			second_q <= d2_val;
			sat_q    <= d1_sat || d2_sat;
		end
	end

	assign root_out.valid        = out_v_q;
	assign root_out.root_kind    = kind_q;
	assign root_out.first_value  = first_q;
	assign root_out.second_value = second_q;
	assign root_out.saturated    = sat_q;

endmodule

>>> rtl/core/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Solves a*x^2 + b*x + c = 0 for Q8.8 coefficients, Q16.16 saturated roots.
// ----------------------------------------------------------------------------
// One coefficient request is taken per cycle unless the front holds a request
// that the full queue cannot take, and each yields one result. The front
// registers the products, forms the discriminant and classifies the request
// into a four-entry queue; the back runs a 33-stage square root, a numerator
// stage, two 33-stage dividers and an output register. The whole back pipeline
// holds while the result waits to be taken, and the queue keeps the front accepting meanwhile.
module quadratic_root_solver_core
	import qrs_pkg::*;
#(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coef_in,
	qrs_root_if.source root_out
);

	logic  push;
	logic  full;
	logic  pop;
	logic  empty;
	item_t front_item;
	item_t back_item;

	qrs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef_in (coef_in),
		.full    (full),
		.push    (push),
		.item    (front_item)
	);

	qrs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item_i (front_item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.item_o (back_item)
	);

	qrs_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (back_item),
		.empty    (empty),
		.pop      (pop),
		.root_out (root_out)
	);

endmodule

>>> tb/quadratic_root_solver_core_tb.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_tb
// Feeds coefficient requests through the solver and checks every root result
// against an independent predictor, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_tb;
	import qrs_pkg::*;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
	} coef_t;

	typedef struct {
		kind_t              kind;
		logic signed [31:0] first;
		logic signed [31:0] second;
		logic               sat;
	} roots_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;

	qrs_coef_if coef_ch ();
	qrs_root_if root_ch ();

	quadratic_root_solver_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef_in (coef_ch.sink),
		.root_out(root_ch.source)
	);

	coef_t  pending_q[$];
	roots_t expected_q[$];
	int     errors;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     idle_cycles;
	bit     stim_done;
	bit     in_taken;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] scaled_quotient(longint num, longint a,
		inout logic sat);
		logic        neg;
		logic [63:0] un, ua, n, den, q, lim;
		neg = (num < 0) != (a < 0);
		un  = num < 0 ? -num : num;
		ua  = a < 0 ? -a : a;
		n   = un << 16;
		den = ua << (SQRT_SCALE + 1);
		q   = (2 * n + den) / (2 * den);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (un == 0)
			return 32'sd0;
		if (q > lim) begin
			q   = lim;
			sat = 1'b1;
		end
		return neg ? 32'(-q) : 32'(q);
	endfunction

	function automatic roots_t solve_roots(coef_t co);
		roots_t      r;
		longint      a, b, c, d, bs;
		logic [63:0] ud, rt;
		a = co.a;
		b = co.b;
		c = co.c;
		r.kind   = KIND_DEGEN;
		r.first  = 0;
		r.second = 0;
		r.sat    = 1'b0;
		if (a == 0)
			return r;
		d  = b * b - 4 * a * c;
		ud = d < 0 ? -d : d;
		rt = isqrt(ud << (2 * SQRT_SCALE));
		bs = -b * (longint'(1) << SQRT_SCALE);
		if (d > 0) begin
			r.kind   = KIND_TWO_REAL;
			r.first  = scaled_quotient(bs + longint'(rt), a, r.sat);
			r.second = scaled_quotient(bs - longint'(rt), a, r.sat);
		end else if (d == 0) begin
			r.kind  = KIND_DOUBLE;
			r.first = scaled_quotient(bs, a, r.sat);
		end else begin
			r.kind   = KIND_COMPLEX;
			r.first  = scaled_quotient(bs, a, r.sat);
			r.second = scaled_quotient(longint'(rt), a, r.sat);
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic add_request(int a, int b, int c);
		coef_t co;
		co.a = 16'(a);
		co.b = 16'(b);
		co.c = 16'(c);
		pending_q.push_back(co);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_q.size() > 0 && ((coef_ch.valid && !in_taken) ||
				$urandom_range(99) >= send_idle_pct)) begin
				coef_ch.valid  <= 1'b1;
				coef_ch.coef_a <= pending_q[0].a;
				coef_ch.coef_b <= pending_q[0].b;
				coef_ch.coef_c <= pending_q[0].c;
			end else begin
				coef_ch.valid <= 1'b0;
			end
			root_ch.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		roots_t e;
		coef_t  co;
		if (arst_n) begin
			in_taken = coef_ch.valid && coef_ch.ready;
			if (in_taken) begin
				co.a = coef_ch.coef_a;
				co.b = coef_ch.coef_b;
				co.c = coef_ch.coef_c;
				expected_q.push_back(solve_roots(co));
				void'(pending_q.pop_front());
			end
			if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (root_ch.valid && root_ch.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					e = expected_q.pop_front();
					if (root_ch.root_kind !== e.kind)
						report_mismatch($sformatf("root_kind %0d, expected %0d",
							root_ch.root_kind, e.kind));
					if (root_ch.first_value !== e.first)
						report_mismatch($sformatf("first_value %0d, expected %0d",
							root_ch.first_value, e.first));
					if (root_ch.second_value !== e.second)
						report_mismatch($sformatf("second_value %0d, expected %0d",
							root_ch.second_value, e.second));
					if (root_ch.saturated !== e.sat)
						report_mismatch($sformatf("saturated %0b, expected %0b",
							root_ch.saturated, e.sat));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		int a, b, c, r;
		phase_idle  = '{0, 69, 0, 14};
		phase_stall = '{0, 0, 69, 14};
		errors         = 0;
		idle_cycles    = 0;
		stim_done      = 0;
		in_taken       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		coef_ch.valid  = 1'b0;
		coef_ch.coef_a = '0;
		coef_ch.coef_b = '0;
		coef_ch.coef_c = '0;
		root_ch.ready  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: degenerate, double, complex, two real, extremes
		add_request(0, 0, 0);
		add_request(0, -32768, 32767);
		add_request(256, -512, 256);
		add_request(256, 0, 0);
		add_request(256, 0, 256);
		add_request(-256, 0, 256);
		add_request(256, 0, -256);
		add_request(-256, 512, -256);
		add_request(32767, 32767, 32767);
		add_request(-32768, -32768, -32768);
		add_request(-32768, 32767, 32767);
		add_request(1, -32768, 32767);
		add_request(1, 32767, -32768);
		add_request(-1, -32768, -32768);
		add_request(1, 0, -32768);
		add_request(1, 0, 32767);
		add_request(-1, 0, 32767);
		add_request(32767, 0, -32768);
		add_request(1, 2, 1);
		add_request(-32768, 0, 0);
		add_request(65535 & 16'h5555, 16'hAAAA - 65536, 16'h5555);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			for (int i = 0; i < 330; i++) begin
				r = $urandom_range(9);
				a = $signed(16'($urandom));
				b = $signed(16'($urandom));
				c = $signed(16'($urandom));
				if (r < 2) begin
					a = $signed(16'($urandom)) >>> $urandom_range(15);
					b = $signed(16'($urandom)) >>> $urandom_range(15);
					c = $signed(16'($urandom)) >>> $urandom_range(15);
				end else if (r == 2) begin
					// perfect square: a(x-k)^2
					a = $urandom_range(1, 16) * ($urandom_range(1) ? 1 : -1);
					b = $signed(8'($urandom));
					b = b * 2 * a;
					c = b * b / (4 * a);
					if (c > 32767 || c < -32768 || b * b != 4 * a * c)
						c = 0;
					if (c == 0)
						b = 0;
				end else if (r == 3) begin
					a = 0;
				end else if (r == 4) begin
					a = $urandom_range(1) ? 1 : -1;
				end
				add_request(a, b, c);
			end
			while (pending_q.size() > 0 || expected_q.size() > 0)
				@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> quadratic_root_solver_core.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_if.sv
rtl/core/qrs_front.sv
rtl/core/qrs_queue.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver_core.sv
tb/quadratic_root_solver_core_tb.sv
